// File: rtl/eff_pkg.sv
// ----------------------------------------------------------------------------
// eff_pkg
// Shared types and constants of the escaped frame field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package eff_pkg;

  // Default window geometry.
  localparam int FRAME_BYTES_DEF = 22;
  localparam int HEAD_BYTES_DEF  = 14;

  // Decoded payload bytes that make up the three 32-bit fields.
  localparam int FIELD_BYTES = 12;
  localparam int FIELD_IDX_W = $clog2(FIELD_BYTES + 1);

  // Result queue depth, a power of two.
  localparam int RES_DEPTH = 2;

  // Register reset values.
  localparam logic [7:0] START_BYTE_RST  = 8'h7E;
  localparam logic [7:0] END_BYTE_RST    = 8'h0A;
  localparam logic [7:0] ESCAPE_BYTE_RST = 8'h1B;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 2'd0,
    CFG_END    = 2'd1,
    CFG_ESCAPE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
  } cfg_t;

  typedef struct packed {
    logic [31:0] x_value;
    logic [31:0] y_value;
    logic [31:0] weight_value;
    logic        frame_ok;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/eff_front.sv
// ----------------------------------------------------------------------------
// eff_front
// Byte front end: tracks the window position, compares the head against the
// last stored head, decodes escapes and assembles the three fields.
// ----------------------------------------------------------------------------
`default_nettype none

module eff_front
  import eff_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int HEAD_BYTES  = HEAD_BYTES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire logic    byte_vld,
  input  wire logic [7:0] byte_data,
  output logic         res_push,
  output result_t      res_data
);

  localparam int POS_W      = $clog2(FRAME_BYTES);
  localparam int HEAD_IDX_W = (HEAD_BYTES > 1) ? $clog2(HEAD_BYTES) : 1;
  localparam int CMP_W      = POS_W + 6;

  logic [POS_W-1:0]       pos_r;
  logic                   match_r, match_nxt;
  logic                   start_r, start_nxt;
  logic                   esc_r, esc_nxt;
  logic [FIELD_IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]             fld_r   [FIELD_BYTES];
  logic [7:0]             fld_nxt [FIELD_BYTES];
  logic                   prev_vld_r;
  logic                   sel_r;

  // Two head banks: the one chosen by sel_r holds the last stored head, the
  // other collects the head of the running window.
  logic [7:0] bank0_r [HEAD_BYTES];
  logic [7:0] bank1_r [HEAD_BYTES];

  logic [HEAD_IDX_W-1:0] head_idx;
  logic                  in_head;
  logic [7:0]            prev_byte;
  logic                  last;
  logic                  dup;
  logic                  ok;

  always_comb begin
    head_idx  = HEAD_IDX_W'(pos_r);
    in_head   = CMP_W'(pos_r) < CMP_W'(HEAD_BYTES);
    prev_byte = sel_r ? bank1_r[head_idx] : bank0_r[head_idx];
    last      = (pos_r == POS_W'(FRAME_BYTES - 1));

    match_nxt = match_r & ~(in_head & (byte_data != prev_byte));
    start_nxt = (pos_r == '0) ? (byte_data == cfg.start_byte) : start_r;

    fld_nxt = fld_r;
    idx_nxt = idx_r;
    esc_nxt = esc_r;
    if ((pos_r >= POS_W'(2)) && (idx_r != FIELD_IDX_W'(FIELD_BYTES))) begin
      if (esc_r) begin
        esc_nxt        = 1'b0;
        fld_nxt[idx_r] = cfg.escape_byte ^ byte_data;
        idx_nxt        = idx_r + 1'b1;
      end else if (byte_data == cfg.escape_byte) begin
        esc_nxt = 1'b1;
      end else begin
        fld_nxt[idx_r] = byte_data;
        idx_nxt        = idx_r + 1'b1;
      end
    end
    // An escape still open at the window end decodes as the escape byte.
    if (last && esc_nxt && (idx_nxt != FIELD_IDX_W'(FIELD_BYTES))) begin
      fld_nxt[idx_nxt] = cfg.escape_byte;
    end

    dup      = prev_vld_r & match_nxt;
    res_push = byte_vld & last & ~dup;
    ok       = start_nxt & (byte_data == cfg.end_byte);

    res_data.frame_ok     = ok;
    res_data.x_value      = ok ? {fld_nxt[3], fld_nxt[2], fld_nxt[1], fld_nxt[0]} : '0;
    res_data.y_value      = ok ? {fld_nxt[7], fld_nxt[6], fld_nxt[5], fld_nxt[4]} : '0;
    res_data.weight_value = ok ? {fld_nxt[11], fld_nxt[10], fld_nxt[9], fld_nxt[8]} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      match_r    <= 1'b1;
      start_r    <= 1'b0;
      esc_r      <= 1'b0;
      idx_r      <= '0;
      prev_vld_r <= 1'b0;
      sel_r      <= 1'b0;
      for (int i = 0; i < FIELD_BYTES; i++) begin
        fld_r[i] <= '0;
      end
    end else if (byte_vld) begin
      if (last) begin
        pos_r   <= '0;
        match_r <= 1'b1;
        start_r <= 1'b0;
        esc_r   <= 1'b0;
        idx_r   <= '0;
        for (int i = 0; i < FIELD_BYTES; i++) begin
          fld_r[i] <= '0;
        end
        if (!dup) begin
          prev_vld_r <= 1'b1;
          sel_r      <= ~sel_r;
        end
      end else begin
        pos_r   <= pos_r + 1'b1;
        match_r <= match_nxt;
        start_r <= start_nxt;
        esc_r   <= esc_nxt;
        idx_r   <= idx_nxt;
        fld_r   <= fld_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld && in_head) begin
      if (sel_r) begin
        bank0_r[head_idx] <= byte_data;
      end else begin
        bank1_r[head_idx] <= byte_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/eff_fifo.sv
// ----------------------------------------------------------------------------
// eff_fifo
// Short result queue between the byte front end and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module eff_fifo
  import eff_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    pop,
  output logic         full,
  output logic         empty,
  output result_t      head_data
);

  localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  result_t          mem_r [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(RES_DEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & ~empty;
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/escaped_frame_field_extractor_top.sv
// ----------------------------------------------------------------------------
// escaped_frame_field_extractor_top
// Deframer for byte-stuffed frames carrying three 32-bit little-endian fields.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter as queue pushes (in_push / in_full), one beat per
//   byte, and are grouped into windows of FRAME_BYTES bytes. A window whose
//   first HEAD_BYTES bytes repeat the last stored head is dropped; every
//   other window yields one result beat on the output queue (out_empty /
//   out_pop) carrying x, y, weight and frame_ok. Values are zero when the
//   window did not open with the start byte and close with the end byte.
//   The input takes one byte every cycle while in_full is low. A result is
//   queued in the cycle after the last byte of its window was accepted.
//   Results wait in a two-entry queue; in_full rises only while both entries
//   are occupied, which takes the receiver stalling across two whole windows.
//   The configuration port (cfg_valid / cfg_ready, always ready) sets the
//   start, end and escape bytes; write it only while the block is idle.
//   Reset is synchronous: it restores the register defaults, starts a fresh
//   window, forgets the stored head and empties the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_field_extractor_top
  import eff_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int HEAD_BYTES  = HEAD_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Byte input queue.
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [7:0]           in_rx_byte,
  // Result output queue.
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [31:0]               out_x_value,
  output logic [31:0]               out_y_value,
  output logic [31:0]               out_weight_value,
  output logic                      out_frame_ok,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t    cfg_r;
  logic    byte_acc;
  logic    res_push;
  result_t res_data;
  result_t head_data;

  // Registers are always writable; an unknown index is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= START_BYTE_RST;
      cfg_r.end_byte    <= END_BYTE_RST;
      cfg_r.escape_byte <= ESCAPE_BYTE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START:  cfg_r.start_byte  <= cfg_data;
        CFG_END:    cfg_r.end_byte    <= cfg_data;
        CFG_ESCAPE: cfg_r.escape_byte <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A byte is taken whenever the result queue has room, so a window end can
  // always deposit its result.
  assign byte_acc = in_push & ~in_full;

  eff_front #(
    .FRAME_BYTES(FRAME_BYTES),
    .HEAD_BYTES (HEAD_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .byte_vld (byte_acc),
    .byte_data(in_rx_byte),
    .res_push (res_push),
    .res_data (res_data)
  );

  eff_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .pop      (out_pop),
    .full     (in_full),
    .empty    (out_empty),
    .head_data(head_data)
  );

  assign out_x_value      = head_data.x_value;
  assign out_y_value      = head_data.y_value;
  assign out_weight_value = head_data.weight_value;
  assign out_frame_ok     = head_data.frame_ok;

endmodule

`default_nettype wire

// File: rtl/eff_checker.sv
// ----------------------------------------------------------------------------
// eff_checker
// Port-level checks of the escaped frame field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

module eff_checker
  import eff_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [31:0] out_x_value,
  input wire logic [31:0] out_y_value,
  input wire logic [31:0] out_weight_value,
  input wire logic        out_frame_ok
);

  // Reset leaves the result queue empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A bad frame carries all-zero values.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_frame_ok) |->
      (out_x_value == 32'd0 && out_y_value == 32'd0 && out_weight_value == 32'd0))
    else $error("bad frame with nonzero values");

  // Input back-pressure only comes from results waiting at the output.
  a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input full while no result waits");

  // A waiting result that is not taken stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_x_value) && $stable(out_y_value) &&
       $stable(out_weight_value) && $stable(out_frame_ok)))
    else $error("waiting result changed or vanished");

endmodule

bind escaped_frame_field_extractor_top eff_checker u_eff_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_push         (in_push),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_x_value     (out_x_value),
  .out_y_value     (out_y_value),
  .out_weight_value(out_weight_value),
  .out_frame_ok    (out_frame_ok)
);

`default_nettype wire

// File: bench/tb_escaped_frame_field_extractor_top.sv
// ----------------------------------------------------------------------------
// tb_escaped_frame_field_extractor_top
// Self-checking bench for the byte-stuffed frame deframer.
// ----------------------------------------------------------------------------
// Windows of received bytes are built to shape: well-formed frames with
// escaped payloads, escape-heavy frames with short payloads, repeated heads,
// broken start or end bytes, and raw noise. A clocked driver pushes them one
// byte per beat, and a behavioral model of the deframer predicts every result
// beat. A clocked monitor pops the result queue and compares each beat field
// by field. The run walks through several register settings and several
// idling mixes, and it holds the receiver off long enough to fill the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_escaped_frame_field_extractor_top
  import eff_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN    = FRAME_BYTES_DEF;
  localparam int HEAD_LEN     = HEAD_BYTES_DEF;
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 10;
  // The block queues its result in the cycle after the last byte of a window;
  // the settle time covers any work in flight on a window that yields nothing.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int TIMEOUT_NS    = 4_000_000;

  // The index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Shapes of generated byte windows.
  typedef enum int {
    WIN_GOOD,
    WIN_DENSE,
    WIN_REPEAT,
    WIN_BAD_START,
    WIN_BAD_END,
    WIN_NOISE,
    WIN_ZEROS,
    WIN_ONES
  } win_kind_t;

  // Every input starts at a known value so nothing floats before reset.
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_push    = 1'b0;
  logic                 in_full;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_empty;
  logic                 out_pop    = 1'b0;
  logic [31:0]          out_x_value;
  logic [31:0]          out_y_value;
  logic [31:0]          out_weight_value;
  logic                 out_frame_ok;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [7:0]           cfg_data   = 8'h00;

  escaped_frame_field_extractor_top #(
    .FRAME_BYTES(FRAME_LEN),
    .HEAD_BYTES (HEAD_LEN)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_rx_byte      (in_rx_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_x_value     (out_x_value),
    .out_y_value     (out_y_value),
    .out_weight_value(out_weight_value),
    .out_frame_ok    (out_frame_ok),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state. The register copies are shared by the window builder and the
  // deframer model; they only change while the block is idle, so both always
  // see the setting that the block itself is using.
  // --------------------------------------------------------------------------
  logic [7:0] reg_start_byte  = START_BYTE_RST;
  logic [7:0] reg_end_byte    = END_BYTE_RST;
  logic [7:0] reg_escape_byte = ESCAPE_BYTE_RST;

  // Deframer model state, at its reset values.
  int          win_pos       = 0;
  logic [7:0]  stored_head [HEAD_LEN] = '{default: 8'h00};
  logic        stored_vld    = 1'b0;
  logic [7:0]  cur_head    [HEAD_LEN] = '{default: 8'h00};
  logic        head_same     = 1'b1;
  logic        start_ok      = 1'b0;
  logic        esc_pend      = 1'b0;
  logic [95:0] dec_bytes     = '0;
  int          dec_count     = 0;

  logic [7:0] rx_backlog[$];         // bytes waiting for the driver
  result_t    expected_results[$];   // predicted result beats, oldest first
  logic [7:0] last_head [HEAD_LEN];  // head of the most recently built window

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic recv_hold    = 1'b0;

  int error_count     = 0;
  int bytes_taken     = 0;
  int windows_built   = 0;
  int results_checked = 0;
  int frames_good     = 0;
  int windows_dropped = 0;
  int full_cycles     = 0;

  // --------------------------------------------------------------------------
  // Deframer model: advances one byte and queues a result beat at the end of
  // every window whose head differs from the stored one.
  // --------------------------------------------------------------------------
  function automatic void predict_byte(input logic [7:0] b);
    logic       got;
    logic [7:0] d;
    result_t    r;
    got = 1'b0;
    d   = 8'h00;
    if (win_pos < HEAD_LEN) begin
      cur_head[win_pos] = b;
      if (b != stored_head[win_pos]) head_same = 1'b0;
    end
    if (win_pos == 0) start_ok = (b == reg_start_byte);

    // Payload decoding starts at byte 2 and stops once twelve bytes are in.
    // Whatever follows an escape is data, even another escape byte.
    if (win_pos >= 2 && dec_count < FIELD_BYTES) begin
      if (esc_pend) begin
        esc_pend = 1'b0;
        got = 1'b1;
        d = b ^ reg_escape_byte;
      end else if (b == reg_escape_byte) begin
        esc_pend = 1'b1;
      end else begin
        got = 1'b1;
        d = b;
      end
    end
    if (got) begin
      dec_bytes[dec_count*8 +: 8] = d;
      dec_count++;
    end

    if (win_pos < FRAME_LEN - 1) begin
      win_pos++;
    end else begin
      if (stored_vld && head_same) begin
        windows_dropped++;
      end else begin
        stored_head = cur_head;
        stored_vld  = 1'b1;
        // An escape left hanging at the window end stands for itself.
        if (esc_pend && dec_count < FIELD_BYTES)
          dec_bytes[dec_count*8 +: 8] = reg_escape_byte;
        r.frame_ok     = start_ok && (b == reg_end_byte);
        r.x_value      = r.frame_ok ? dec_bytes[31:0]  : 32'h0;
        r.y_value      = r.frame_ok ? dec_bytes[63:32] : 32'h0;
        r.weight_value = r.frame_ok ? dec_bytes[95:64] : 32'h0;
        if (r.frame_ok) frames_good++;
        expected_results.push_back(r);
      end
      win_pos   = 0;
      head_same = 1'b1;
      start_ok  = 1'b0;
      esc_pend  = 1'b0;
      dec_bytes = '0;
      dec_count = 0;
    end
  endfunction

  // Payload bytes lean toward the values that steer the decoder.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return reg_escape_byte;
      3: return reg_start_byte;
      4: return reg_end_byte;
      default: return 8'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Window builder. Framed kinds open with the start byte, close with the end
  // byte and stuff the payload; escape-heavy windows decode fewer than twelve
  // bytes, so the last byte (end byte or a dangling escape) lands in the data.
  // --------------------------------------------------------------------------
  task automatic queue_window(input win_kind_t kind);
    logic [7:0] w [FRAME_LEN];
    logic [7:0] v;
    int p;
    for (int i = 0; i < FRAME_LEN; i++) w[i] = 8'($urandom);
    case (kind)
      WIN_NOISE: begin
      end
      WIN_ZEROS: begin
        for (int i = 0; i < FRAME_LEN; i++) w[i] = 8'h00;
      end
      WIN_REPEAT: begin
        // Same head as the stored one; now and then one head byte differs,
        // which must keep the window alive.
        for (int i = 0; i < HEAD_LEN; i++) w[i] = last_head[i];
        if ($urandom_range(3) == 0) begin
          p = $urandom_range(HEAD_LEN - 1);
          w[p] = w[p] ^ 8'($urandom_range(1, 255));
        end
        if ($urandom_range(1) == 0) w[FRAME_LEN-1] = reg_end_byte;
      end
      default: begin
        w[0] = reg_start_byte;
        p = 2;
        while (p < FRAME_LEN - 1) begin
          v = (kind == WIN_ONES) ? 8'hFF : pick_byte();
          if (p < FRAME_LEN - 2 &&
              (v == reg_escape_byte || kind == WIN_DENSE || $urandom_range(99) < 15)) begin
            w[p]   = reg_escape_byte;
            w[p+1] = reg_escape_byte ^ v;
            p += 2;
          end else begin
            w[p] = v;
            p++;
          end
        end
        w[FRAME_LEN-1] = reg_end_byte;
        if (kind == WIN_DENSE && $urandom_range(1) == 0) w[FRAME_LEN-1] = reg_escape_byte;
        if (kind == WIN_BAD_START) w[0] = w[0] ^ 8'($urandom_range(1, 255));
        if (kind == WIN_BAD_END)
          w[FRAME_LEN-1] = w[FRAME_LEN-1] ^ 8'($urandom_range(1, 255));
      end
    endcase
    for (int i = 0; i < HEAD_LEN; i++) last_head[i] = w[i];
    for (int i = 0; i < FRAME_LEN; i++) rx_backlog.push_back(w[i]);
    windows_built++;
  endtask

  task automatic queue_random_windows(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45)      queue_window(WIN_GOOD);
      else if (r < 60) queue_window(WIN_DENSE);
      else if (r < 75) queue_window(WIN_REPEAT);
      else if (r < 82) queue_window(WIN_BAD_START);
      else if (r < 89) queue_window(WIN_BAD_END);
      else if (r < 95) queue_window(WIN_NOISE);
      else if (r < 97) queue_window(WIN_ONES);
      else             queue_window(WIN_ZEROS);
    end
  endtask

  // One register write beat; the model's copy follows once it is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START:  reg_start_byte  = val;
      CFG_END:    reg_end_byte    = val;
      CFG_ESCAPE: reg_escape_byte = val;
      default: ;
    endcase
  endtask

  // Waits until every byte went in and every predicted beat came out, then
  // lets the block settle so a window that yields nothing is surely done.
  // The whole check repeats after the settling time, since a byte that was
  // handed to the driver at the very edge of the first check can still add
  // a result beat.
  task automatic wait_drained();
    do begin
      while (rx_backlog.size() != 0 || in_push) @(posedge clk);
      while (expected_results.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (rx_backlog.size() != 0 || in_push || expected_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Byte driver. A byte stays on the port until the block takes it; every
  // accepted beat goes straight into the model. The next byte, or an idle
  // cycle, is chosen after that, with a single update of in_push per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rx_driver
    logic       push_next;
    logic [7:0] byte_next;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      push_next = in_push;
      byte_next = in_rx_byte;
      if (in_push && in_full) full_cycles++;
      if (in_push && !in_full) begin
        predict_byte(in_rx_byte);
        bytes_taken++;
        push_next = 1'b0;
      end
      if (!push_next && rx_backlog.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        push_next = 1'b1;
        byte_next = rx_backlog.pop_front();
      end
      in_push    <= push_next;
      in_rx_byte <= byte_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. A beat is taken at an edge where out_pop is high and
  // out_empty is low; the values on the ports at that edge are the beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: x_value %h y_value %h weight_value %h frame_ok %b",
                 out_x_value, out_y_value, out_weight_value, out_frame_ok);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_x_value !== want.x_value) begin
            $error("x_value: expected %h, actual %h", want.x_value, out_x_value);
            error_count++;
          end
          if (out_y_value !== want.y_value) begin
            $error("y_value: expected %h, actual %h", want.y_value, out_y_value);
            error_count++;
          end
          if (out_weight_value !== want.weight_value) begin
            $error("weight_value: expected %h, actual %h",
                   want.weight_value, out_weight_value);
            error_count++;
          end
          if (out_frame_ok !== want.frame_ok) begin
            $error("frame_ok: expected %b, actual %b", want.frame_ok, out_frame_ok);
            error_count++;
          end
        end
      end
      out_pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < HEAD_LEN; i++) last_head[i] = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed windows at the reset setting, no idling. An all-zero head
    // must not match the cleared store before any head was kept; the second
    // copy must then be dropped. Then all-ones payload, an escape-heavy short
    // payload, a broken end, a repeated head and a broken start.
    queue_window(WIN_ZEROS);
    queue_window(WIN_ZEROS);
    queue_window(WIN_ONES);
    queue_window(WIN_GOOD);
    queue_window(WIN_DENSE);
    queue_window(WIN_BAD_END);
    queue_window(WIN_REPEAT);
    queue_window(WIN_BAD_START);
    wait_drained();

    // Extreme bytes, plus a write to the unused index that must change
    // nothing. Traffic runs with no idling on either side.
    write_reg(CFG_START, 8'h00);
    write_reg(CFG_END, 8'hFF);
    write_reg(CFG_ESCAPE, 8'h80);
    write_reg(CFG_UNUSED, 8'hFF);
    write_reg(CFG_UNUSED, 8'h00);
    queue_random_windows(9);
    wait_drained();

    // Start and escape share a value; the sender idles often.
    write_reg(CFG_START, 8'hFF);
    write_reg(CFG_END, 8'h00);
    write_reg(CFG_ESCAPE, 8'hFF);
    send_idle_pct  = 62;
    recv_stall_pct = 0;
    queue_random_windows(9);
    wait_drained();

    // End and escape share a value, so a dangling escape can close a good
    // frame; the receiver stalls often.
    write_reg(CFG_START, 8'($urandom));
    write_reg(CFG_ESCAPE, 8'($urandom));
    write_reg(CFG_END, reg_escape_byte);
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    queue_random_windows(9);
    wait_drained();

    // Random setting, both sides idling a third of the time.
    write_reg(CFG_START, 8'($urandom));
    write_reg(CFG_END, 8'($urandom));
    write_reg(CFG_ESCAPE, 8'($urandom));
    send_idle_pct  = 33;
    recv_stall_pct = 33;
    queue_random_windows(9);
    wait_drained();

    // Back to the reset setting. The receiver holds off for a long stretch
    // while the sender keeps pushing, so the result queue fills and in_full
    // stalls the byte input.
    write_reg(CFG_START, START_BYTE_RST);
    write_reg(CFG_END, END_BYTE_RST);
    write_reg(CFG_ESCAPE, ESCAPE_BYTE_RST);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join_none
    for (int n = 0; n < 6; n++) queue_window(WIN_GOOD);
    wait_drained();

    $display("Sent %0d bytes in %0d windows over five register settings and four idling mixes.",
             bytes_taken, windows_built);
    $display("Checked %0d result beats (%0d good frames), %0d repeats dropped, %0d full cycles.",
             results_checked, frames_good, windows_dropped, full_cycles);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
